/* design/nsm_pkg.sv */
// ---------------------------------------------------------------------------
// nsm_pkg : shared types and constants for the nixie scan multiplexer
// Input kinds, pin translation table and the decimal split helper.
// ---------------------------------------------------------------------------
package nsm_pkg;

	// Input transaction kinds carried in tuser
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SET  = 1'b1;

	// Tube count that the digit store always holds
	localparam int STORE_TUBES = 4;

	// Largest value shown on a tube pair
	localparam logic [6:0] PAIR_MAX = 7'd99;

	// Cathode mask for the lower nibble
	localparam logic [3:0] CATHODE_MASK = 4'hf;

	// One decimal digit pair, tens and ones
	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] ones;
	} digit_pair_t;

	// Digit to cathode pin code translation
	function automatic logic [3:0] pin_xlat(input logic [3:0] digit);
		logic [3:0] code;
		case (digit)
			4'd0:    code = 4'd1;
			4'd1:    code = 4'd0;
			4'd2:    code = 4'd9;
			4'd3:    code = 4'd8;
			4'd4:    code = 4'd7;
			4'd5:    code = 4'd6;
			4'd6:    code = 4'd5;
			4'd7:    code = 4'd4;
			4'd8:    code = 4'd3;
			4'd9:    code = 4'd2;
			default: code = 4'd1;
		endcase
		return code & CATHODE_MASK;
	endfunction

	// Saturate at 99, then split into tens and ones.
	// tens = (v * 205) >> 11 is exact for v up to 179.
	function automatic digit_pair_t split_pair(input logic [6:0] value);
		logic [6:0]  sat;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		digit_pair_t res;
		sat  = (value > PAIR_MAX) ? PAIR_MAX : value;
		prod = 15'(sat) * 15'd205;
		tens = prod[14:11];
		ones = sat - 7'(tens) * 7'd10;
		res.tens = tens;
		res.ones = ones[3:0];
		return res;
	endfunction

endpackage

/* design/nsm_tube_cell.sv */
// ---------------------------------------------------------------------------
// nsm_tube_cell : one tube of the scan chain
// Holds one stored pin word and passes the selected word down the chain.
// ---------------------------------------------------------------------------
module nsm_tube_cell import nsm_pkg::*; #(
	parameter int TUBE = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       set_en,     // load a new digit
	input  logic [3:0] digit,      // decimal digit for this tube
	input  logic [1:0] sel,        // tube being read out
	input  logic [7:0] word_in,    // word from the previous cell
	output logic [7:0] word_out    // word to the next cell
);

	localparam logic [1:0] MY_IDX = 2'(TUBE);
	localparam logic [3:0] ANODE  = 4'(1 << TUBE);

	logic [7:0] word_q;

	// Stored word, blank after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= 8'h00;
		end else if (set_en) begin
			word_q <= {ANODE, pin_xlat(digit)};
		end
	end

	// Take over the chain when this tube is selected
	assign word_out = (sel == MY_IDX) ? word_q : word_in;

endmodule

/* design/nixie_scan_multiplexer.sv */
// ---------------------------------------------------------------------------
// nixie_scan_multiplexer : scan driver for multiplexed nixie tubes
// Stores four digit words and alternates blank and display scan phases.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  s_axis   | in        | s_tvalid / s_tready  | tuser kind, tdata hour, minute
//  m_axis   | out       | m_tvalid / m_tready  | tdata pin_word
//  cfg      | in        | cfg_valid / cfg_ready| cfg_data display_enable
//
// One input transaction per cycle while s_tready is high; a tick's result is
// registered in the output register, or in the skid while the output stalls.
// A two-entry output stage (register plus skid) keeps s_tready high while
// one result waits; s_tready drops only when both entries are full.
// arst_n clears the digit store to blank, the scan index to NUM_TUBES,
// selects the display phase next and enables the display.
// ---------------------------------------------------------------------------
module nixie_scan_multiplexer import nsm_pkg::*; #(
	parameter int NUM_TUBES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [6:0] hour, [13:7] minute, [15:14] zero
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] pin_word
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // [0] display_enable
);

	localparam logic [2:0] NT = 3'(NUM_TUBES);

	logic        enable_q;
	logic        blank_next_q;
	logic [2:0]  scan_q;
	logic        m_valid_q;
	logic [7:0]  m_data_q;
	logic        skid_valid_q;
	logic [7:0]  skid_data_q;

	logic        in_acc;
	logic        is_set;
	logic        is_show;
	logic        push;
	logic [7:0]  result;
	logic [2:0]  scan_next;
	digit_pair_t hour_d;
	digit_pair_t min_d;
	logic [3:0]  digits [STORE_TUBES];
	logic [7:0]  chain  [STORE_TUBES+1];

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid) begin
			enable_q <= cfg_data;
		end
	end

	// Input decode
	assign s_tready = !skid_valid_q;
	assign in_acc   = s_tvalid && s_tready;
	assign is_set   = in_acc && (s_tuser == KIND_SET);
	assign is_show  = in_acc && (s_tuser == KIND_TICK) && blank_next_q && enable_q;
	assign push     = is_show || (in_acc && (s_tuser == KIND_TICK) && !blank_next_q);

	// Decimal split of hour and minute
	assign hour_d    = split_pair(s_tdata[6:0]);
	assign min_d     = split_pair(s_tdata[13:7]);
	assign digits[0] = hour_d.tens;
	assign digits[1] = hour_d.ones;
	assign digits[2] = min_d.tens;
	assign digits[3] = min_d.ones;

	// Next scan index, wrapping at zero or out of range
	assign scan_next = (scan_q == 3'd0 || scan_q > NT) ? NT - 3'd1 : scan_q - 3'd1;

	// Row of tube cells, selected word ripples to the end
	assign chain[0] = 8'h00;
	for (genvar i = 0; i < STORE_TUBES; i++) begin : g_cell
		nsm_tube_cell #(.TUBE(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.set_en   (is_set),
			.digit    (digits[i]),
			.sel      (scan_next[1:0]),
			.word_in  (chain[i]),
			.word_out (chain[i+1])
		);
	end

	assign result = is_show ? chain[STORE_TUBES] : 8'h00;

	// Scan phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_next_q <= 1'b1;
			scan_q       <= NT;
		end else if (is_show) begin
			blank_next_q <= 1'b0;
			scan_q       <= scan_next;
		end else if (push) begin
			blank_next_q <= 1'b1;
		end
	end

	// Output register and skid, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q    <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output register and skid, payload
	always_ff @(posedge clk) begin
		if (!m_valid_q || m_tready) begin
			m_data_q <= skid_valid_q ? skid_data_q : result;
		end else if (push) begin
			skid_data_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

/* design/nsm_checker.sv */
// ---------------------------------------------------------------------------
// nsm_checker : port-level checks for the nixie scan multiplexer
// Watches the top level ports; attached by the bind below.
// ---------------------------------------------------------------------------
module nsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// Stalled output transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	// Non-blank word drives exactly one anode
	a_anode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata != 8'h00) |-> $onehot(m_tdata[7:4]))
		else $error("pin word anode not one-hot");

	// Cathode code is a translated decimal digit
	a_cathode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= 4'd9)
		else $error("cathode code out of range");

	// Input stalls only with a result waiting
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

endmodule

bind nixie_scan_multiplexer nsm_checker u_nsm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
